// ===== hw/rtl/hsx_pkg.sv =====
// ============================================================================
// hsx_pkg
// Shared types and codes for the HSL/HSV/HSI to RGB converter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hsx_pkg;

    // field widths fixed by the pixel format, and the APB bus widths
    localparam int CH_W   = 13;
    localparam int HUE_W  = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // colour model codes; the unused code behaves as HSV
    localparam logic [1:0] MODEL_HSL = 2'd0;
    localparam logic [1:0] MODEL_HSV = 2'd1;
    localparam logic [1:0] MODEL_HSI = 2'd2;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             hue_undefined;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  level;
        logic [CH_W-1:0]  alpha_in;
    } t_hsx_in;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha_out;
    } t_rgb_out;

endpackage

`default_nettype wire

// ===== hw/rtl/hsx_div.sv =====
// ============================================================================
// hsx_div
// Pipelined restoring divider: one quotient bit per stage, with a side
// payload that travels alongside each transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsx_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 30,
    parameter int Q_W    = 14,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quot,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]     r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_quot [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic [Q_W-1:0]    r_vld;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [CW-1:0]     rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quot_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [CW-1:0]     den_sh;
        logic [CW-1:0]     n_rem;
        logic [Q_W-1:0]    n_quot;

        // take the previous stage, or the ports for the first one
        if (k == 0) begin : g_first
            assign rem_in  = CW'(i_num);
            assign den_in  = i_den;
            assign quot_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quot_in = r_quot[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb begin
            den_sh = CW'(den_in) << B;
            n_rem  = rem_in;
            n_quot = quot_in;
            if (rem_in >= den_sh) begin
                n_rem     = rem_in - den_sh;
                n_quot[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_den[k]  <= den_in;
            r_quot[k] <= n_quot;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/hsx_to_rgb_converter_core.sv =====
// ============================================================================
// hsx_to_rgb_converter_core
// Converts hue, saturation and level to RGB for the HSL, HSV or HSI model.
// ============================================================================
// From start to o_done: stages 1 to 3, the HSI chroma divider (one stage
//   per quotient bit, FRAC_BITS + 2 bits), stage X and the final stage.
// Throughput: one transaction per cycle; busy is never raised.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits and sets the model
//   register to HSV.
`timescale 1ns / 1ps
`default_nettype none

module hsx_to_rgb_converter_core #(
    parameter int FRAC_BITS = 12,
    parameter int HUE_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire hsx_pkg::t_hsx_in             i_pixel,
    output logic                              o_done,
    output hsx_pkg::t_rgb_out                 o_pixel,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hsx_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hsx_pkg::APB_DW-1:0]   pwdata,
    output logic [hsx_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int F       = FRAC_BITS;
    localparam int H       = HUE_BITS;
    localparam int ONE     = 1 << F;
    localparam int HUE_ONE = 1 << H;
    localparam int V_W     = F + 1;
    localparam int Q_W     = F + 2;
    localparam int PC_W    = 2 * F + 4;
    localparam int PM_W    = 2 * F + 2;
    localparam int D_W     = H + 2;
    localparam int DEN_W   = D_W + F;
    localparam int NUM_W   = PC_W + H + 1;
    localparam int CW_W    = Q_W + H + 1;
    localparam int SIDE_W  = 3 * V_W + 2 + 3 + (H + 1) + 1;
    localparam int LATENCY = F + 7;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [1:0] r_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= hsx_pkg::MODEL_HSV;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_model <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : hsx_pkg::APB_DW'(r_model);
    assign busy   = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: clamp inputs, split hue into sector and weight
    // ------------------------------------------------------------------
    logic [H-1:0]   hue_m;
    logic [H+2:0]   h6;
    logic [2:0]     n_sec;
    logic [H:0]     n_w;
    logic [V_W-1:0] n_s, n_l, n_a;

    always_comb begin
        hue_m = H'(i_pixel.hue);
        h6    = ((H + 3)'(hue_m) << 2) + ((H + 3)'(hue_m) << 1);
        n_sec = h6[H+2:H];
        n_w   = n_sec[0] ? ((H + 1)'(HUE_ONE) - (H + 1)'(h6[H-1:0]))
                         : (H + 1)'(h6[H-1:0]);
        n_s   = (32'(i_pixel.saturation) > ONE) ? V_W'(ONE) : V_W'(i_pixel.saturation);
        n_l   = (32'(i_pixel.level) > ONE)      ? V_W'(ONE) : V_W'(i_pixel.level);
        n_a   = (32'(i_pixel.alpha_in) > ONE)   ? V_W'(ONE) : V_W'(i_pixel.alpha_in);
    end

    logic           r1_vld;
    logic [2:0]     r1_sec;
    logic [H:0]     r1_w;
    logic [V_W-1:0] r1_s, r1_l, r1_a;
    logic           r1_und;
    logic [1:0]     r1_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sec   <= n_sec;
        r1_w     <= n_w;
        r1_s     <= n_s;
        r1_l     <= n_l;
        r1_a     <= n_a;
        r1_und   <= i_pixel.hue_undefined;
        r1_model <= r_model;
    end

    // ------------------------------------------------------------------
    // stage 2: chroma and HSI offset products
    // ------------------------------------------------------------------
    logic [F+1:0]   two_l, l_dev;
    logic [F+2:0]   opa;
    logic [PC_W-1:0] n_pc;
    logic [PM_W-1:0] n_pm;
    logic [D_W-1:0]  n_d;

    always_comb begin
        two_l = (F + 2)'(r1_l) << 1;
        l_dev = (two_l >= (F + 2)'(ONE)) ? two_l - (F + 2)'(ONE)
                                         : (F + 2)'(ONE) - two_l;
        if (r1_model == hsx_pkg::MODEL_HSL) begin
            opa = (F + 3)'(ONE) - (F + 3)'(l_dev);
        end else if (r1_model == hsx_pkg::MODEL_HSI) begin
            opa = ((F + 3)'(r1_l) << 1) + (F + 3)'(r1_l);
        end else begin
            opa = (F + 3)'(r1_l);
        end
        n_pc = PC_W'(opa) * PC_W'(r1_s);
        n_pm = PM_W'(r1_l) * PM_W'(V_W'(ONE) - r1_s);
        n_d  = D_W'(HUE_ONE) + D_W'(r1_w);
    end

    logic            r2_vld;
    logic [PC_W-1:0] r2_pc;
    logic [PM_W-1:0] r2_pm;
    logic [D_W-1:0]  r2_d;
    logic [2:0]      r2_sec;
    logic [H:0]      r2_w;
    logic [V_W-1:0]  r2_l, r2_a;
    logic            r2_und;
    logic [1:0]      r2_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pc    <= n_pc;
        r2_pm    <= n_pm;
        r2_d     <= n_d;
        r2_sec   <= r1_sec;
        r2_w     <= r1_w;
        r2_l     <= r1_l;
        r2_a     <= r1_a;
        r2_und   <= r1_und;
        r2_model <= r1_model;
    end

    // ------------------------------------------------------------------
    // stage 3: round chroma, offset m, divider operands
    // ------------------------------------------------------------------
    logic [PC_W-1:0]  pc_rnd;
    logic [PM_W-1:0]  pm_rnd;
    logic [V_W-1:0]   n_cs, n_m, cs_half;
    logic [DEN_W-1:0] n_den;
    logic [NUM_W-1:0] n_num;

    always_comb begin
        pc_rnd  = r2_pc + PC_W'(ONE / 2);
        n_cs    = V_W'(pc_rnd >> F);
        pm_rnd  = r2_pm + PM_W'(ONE / 2);
        cs_half = n_cs >> 1;
        if (r2_model == hsx_pkg::MODEL_HSL) begin
            n_m = (r2_l >= cs_half) ? r2_l - cs_half : '0;
        end else if (r2_model == hsx_pkg::MODEL_HSI) begin
            n_m = V_W'(pm_rnd >> F);
        end else begin
            n_m = (r2_l >= n_cs) ? r2_l - n_cs : '0;
        end
        n_den = DEN_W'(r2_d) << F;
        n_num = (NUM_W'(r2_pc) << H) + NUM_W'(n_den >> 1);
    end

    logic              r3_vld;
    logic [NUM_W-1:0]  r3_num;
    logic [DEN_W-1:0]  r3_den;
    logic [SIDE_W-1:0] r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_num  <= n_num;
        r3_den  <= n_den;
        r3_side <= {n_cs, n_m, r2_a, r2_model, r2_sec, r2_w, r2_und};
    end

    // ------------------------------------------------------------------
    // HSI chroma divider; other models ride through alongside
    // ------------------------------------------------------------------
    logic              dv_vld;
    logic [Q_W-1:0]    dv_q;
    logic [SIDE_W-1:0] dv_side;

    hsx_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (Q_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (dv_vld),
        .o_quot  (dv_q),
        .o_side  (dv_side)
    );

    logic [V_W-1:0] d_cs, d_m, d_a;
    logic [1:0]     d_model;
    logic [2:0]     d_sec;
    logic [H:0]     d_w;
    logic           d_und;

    assign {d_cs, d_m, d_a, d_model, d_sec, d_w, d_und} = dv_side;

    // ------------------------------------------------------------------
    // stage X: select chroma, product for the secondary component
    // ------------------------------------------------------------------
    logic [Q_W-1:0]  n_c;
    logic [CW_W-1:0] n_cw;

    always_comb begin
        n_c  = (d_model == hsx_pkg::MODEL_HSI) ? dv_q : Q_W'(d_cs);
        n_cw = CW_W'(n_c) * CW_W'(d_w);
    end

    logic            rx_vld;
    logic [Q_W-1:0]  rx_c;
    logic [CW_W-1:0] rx_cw;
    logic [V_W-1:0]  rx_m, rx_a;
    logic [2:0]      rx_sec;
    logic            rx_und;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_vld <= 1'b0;
        end else begin
            rx_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        rx_c   <= n_c;
        rx_cw  <= n_cw;
        rx_m   <= d_m;
        rx_a   <= d_a;
        rx_sec <= d_sec;
        rx_und <= d_und;
    end

    // ------------------------------------------------------------------
    // final stage: place C and X by sector, add offset, saturate
    // ------------------------------------------------------------------
    logic [CW_W-1:0] cw_rnd;
    logic [Q_W-1:0]  x, cr, cg, cb;
    logic [Q_W:0]    sr, sg, sb;
    hsx_pkg::t_rgb_out n_pix;

    always_comb begin
        cw_rnd = rx_cw + CW_W'(HUE_ONE / 2);
        x      = Q_W'(cw_rnd >> H);
        cr     = '0;
        cg     = '0;
        cb     = '0;
        if (!rx_und) begin
            case (rx_sec)
                3'd0: begin cr = rx_c; cg = x;    end
                3'd1: begin cr = x;    cg = rx_c; end
                3'd2: begin cg = rx_c; cb = x;    end
                3'd3: begin cg = x;    cb = rx_c; end
                3'd4: begin cr = x;    cb = rx_c; end
                default: begin cr = rx_c; cb = x; end
            endcase
        end
        sr = (Q_W + 1)'(cr) + (Q_W + 1)'(rx_m);
        sg = (Q_W + 1)'(cg) + (Q_W + 1)'(rx_m);
        sb = (Q_W + 1)'(cb) + (Q_W + 1)'(rx_m);
        n_pix.red       = (sr > (Q_W + 1)'(ONE)) ? hsx_pkg::CH_W'(ONE)
                                                 : hsx_pkg::CH_W'(sr);
        n_pix.green     = (sg > (Q_W + 1)'(ONE)) ? hsx_pkg::CH_W'(ONE)
                                                 : hsx_pkg::CH_W'(sg);
        n_pix.blue      = (sb > (Q_W + 1)'(ONE)) ? hsx_pkg::CH_W'(ONE)
                                                 : hsx_pkg::CH_W'(sb);
        n_pix.alpha_out = hsx_pkg::CH_W'(rx_a);
    end

    logic              r_done;
    hsx_pkg::t_rgb_out r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= rx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_done  = r_done;
    assign o_pixel = r_pix;

endmodule

`default_nettype wire

// ===== hw/rtl/hsx_checker.sv =====
// ============================================================================
// hsx_checker
// Port-level checks on the converter: latency, ranges and register readback.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsx_checker #(
    parameter int FRAC_BITS = 12,
    parameter int LAT       = 19
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire hsx_pkg::t_rgb_out          o_pixel,
    input wire logic                       psel,
    input wire logic                       penable,
    input wire logic                       pwrite,
    input wire logic [hsx_pkg::APB_AW-1:0] paddr,
    input wire logic [hsx_pkg::APB_DW-1:0] pwdata,
    input wire logic [hsx_pkg::APB_DW-1:0] prdata,
    input wire logic                       pready
);

    localparam int ONE = 1 << FRAC_BITS;

    // every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result missing after accepted transaction");

    // channels saturate at one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> 32'(o_pixel.red) <= ONE
                && 32'(o_pixel.green) <= ONE && 32'(o_pixel.blue) <= ONE
                && 32'(o_pixel.alpha_out) <= ONE)
        else $error("output channel above one");

    // a model write reads back on the next cycle
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) |=>
            (paddr[2] || prdata == {30'd0, $past(pwdata[1:0])}))
        else $error("model register readback mismatch");

    // a result only follows a transaction accepted one latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("spurious result");

endmodule

bind hsx_to_rgb_converter_core hsx_checker #(
    .FRAC_BITS (FRAC_BITS),
    .LAT       (LATENCY)
) u_hsx_checker (.*);

`default_nettype wire

// ===== bench/tb_hsx_to_rgb_converter_core.sv =====
// ============================================================================
// tb_hsx_to_rgb_converter_core
// Self-checking bench: drives pixels under all colour models, predicts each
// RGB result in fixed point and compares it field by field as results strobe.
// ============================================================================
`timescale 1ns / 1ps

module tb_hsx_to_rgb_converter_core;

    localparam int FRAC = 12;
    localparam int HBITS = 16;
    localparam longint ONE = 64'd1 << FRAC;
    localparam longint HONE = 64'd1 << HBITS;
    localparam int LAT = FRAC + 7;
    localparam logic [hsx_pkg::APB_AW-1:0] ADDR_MODEL = '0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    hsx_pkg::t_hsx_in i_pixel = '0;
    logic o_done;
    hsx_pkg::t_rgb_out o_pixel;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [hsx_pkg::APB_AW-1:0] paddr = '0;
    logic [hsx_pkg::APB_DW-1:0] pwdata = '0;
    logic [hsx_pkg::APB_DW-1:0] prdata;
    logic pready;

    logic [1:0] model_q = hsx_pkg::MODEL_HSV;
    hsx_pkg::t_rgb_out rgb_pending[$];
    int errors = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;

    hsx_to_rgb_converter_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel(i_pixel), .o_done(o_done), .o_pixel(o_pixel),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint sat1(longint v);
        return v > ONE ? ONE : v;
    endfunction

    function automatic longint rdiv(longint n, longint d);
        return (n + d / 2) / d;
    endfunction

    // work out the expected RGB for one pixel under the current model
    function automatic hsx_pkg::t_rgb_out convert_pixel(hsx_pkg::t_hsx_in p);
        longint hue, s, l, h6, sector, fr, w, c, m, x, r, g, b, l_dev;
        hsx_pkg::t_rgb_out res;
        hue = p.hue;
        s = sat1(p.saturation);
        l = sat1(p.level);
        h6 = hue * 6;
        sector = h6 >> HBITS;
        fr = h6 & (HONE - 1);
        w = sector[0] ? HONE - fr : fr;
        if (model_q == hsx_pkg::MODEL_HSL) begin
            l_dev = (2 * l >= ONE) ? 2 * l - ONE : ONE - 2 * l;
            c = rdiv((ONE - l_dev) * s, ONE);
            m = (l >= (c >> 1)) ? l - (c >> 1) : 0;
        end else if (model_q == hsx_pkg::MODEL_HSI) begin
            c = rdiv((3 * l * s) << HBITS, ONE * (HONE + w));
            m = rdiv(l * (ONE - s), ONE);
        end else begin
            c = rdiv(l * s, ONE);
            m = (l >= c) ? l - c : 0;
        end
        x = rdiv(c * w, HONE);
        r = 0; g = 0; b = 0;
        if (!p.hue_undefined) begin
            case (sector)
                0: begin r = c; g = x; end
                1: begin r = x; g = c; end
                2: begin g = c; b = x; end
                3: begin g = x; b = c; end
                4: begin r = x; b = c; end
                default: begin r = c; b = x; end
            endcase
        end
        res.red = hsx_pkg::CH_W'(sat1(r + m));
        res.green = hsx_pkg::CH_W'(sat1(g + m));
        res.blue = hsx_pkg::CH_W'(sat1(b + m));
        res.alpha_out = hsx_pkg::CH_W'(sat1(p.alpha_in));
        return res;
    endfunction

    // compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        hsx_pkg::t_rgb_out exp_px;
        if (i_rst_n && o_done) begin
            if (rgb_pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_pixel);
                errors++;
            end else begin
                exp_px = rgb_pending.pop_front();
                pixels_checked++;
                if (exp_px.red !== o_pixel.red) begin
                    $display("%0t: red exp %0d got %0d", $time, exp_px.red, o_pixel.red);
                    errors++;
                end
                if (exp_px.green !== o_pixel.green) begin
                    $display("%0t: green exp %0d got %0d", $time, exp_px.green,
                             o_pixel.green);
                    errors++;
                end
                if (exp_px.blue !== o_pixel.blue) begin
                    $display("%0t: blue exp %0d got %0d", $time, exp_px.blue, o_pixel.blue);
                    errors++;
                end
                if (exp_px.alpha_out !== o_pixel.alpha_out) begin
                    $display("%0t: alpha exp %0d got %0d", $time, exp_px.alpha_out,
                             o_pixel.alpha_out);
                    errors++;
                end
            end
        end
    end

    // send one pixel transaction and record its expected result; start stays
    // high so that the next transaction can follow in the very next cycle
    task automatic send_pixel(hsx_pkg::t_hsx_in p);
        start <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rgb_pending.push_back(convert_pixel(p));
        pixels_sent++;
    endtask

    // drop start and idle for a number of cycles
    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every pending result has arrived, then let the pipe drain
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    // write the model register over APB while idle
    task automatic write_model(logic [hsx_pkg::APB_DW-1:0] val);
        drain_pipe();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_MODEL; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        model_q = val[1:0];
    endtask

    function automatic logic [12:0] rand_ch();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 13'd0;
        if (k == 1) return 13'(ONE);
        if (k == 2) return 13'($urandom_range(4097, 8191));
        return 13'($urandom_range(0, 4096));
    endfunction

    function automatic hsx_pkg::t_hsx_in rand_pixel();
        hsx_pkg::t_hsx_in p;
        p.hue = 16'($urandom);
        p.hue_undefined = ($urandom_range(0, 7) == 0);
        p.saturation = rand_ch();
        p.level = rand_ch();
        p.alpha_in = rand_ch();
        return p;
    endfunction

    // extremes, sector edges, undefined hue and inputs above one
    task automatic test_directed();
        hsx_pkg::t_hsx_in p;
        logic [15:0] hues[8] = '{16'h0000, 16'h2AAA, 16'h2AAB, 16'h5555,
                                 16'h8000, 16'hAAAB, 16'hD555, 16'hFFFF};
        foreach (hues[k]) begin
            p.hue = hues[k]; p.hue_undefined = 1'b0;
            p.saturation = 13'd4096; p.level = 13'(k * 585); p.alpha_in = 13'(k * 512);
            send_pixel(p);
        end
        p = '{16'h1234, 1'b1, 13'd4096, 13'd2048, 13'd4096};
        send_pixel(p);
        p = '{16'hFFFF, 1'b1, 13'h1FFF, 13'h1FFF, 13'h1FFF};
        send_pixel(p);
        p = '{16'h0000, 1'b0, 13'd0, 13'd0, 13'd0};
        send_pixel(p);
        p = '{16'h1555, 1'b0, 13'd4096, 13'd4096, 13'd4096};
        send_pixel(p);
        p = '{16'h7000, 1'b0, 13'd2048, 13'd4095, 13'd1};
        send_pixel(p);
    endtask

    // bursts of random pixels with random gaps
    task automatic test_random(int count);
        int burst, gap;
        while (count > 0) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (count > 0) begin
                    send_pixel(rand_pixel());
                    count--;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                idle_cycles(gap);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_model(hsx_pkg::MODEL_HSL);
        test_directed();
        test_random(350);
        write_model(hsx_pkg::MODEL_HSI);
        test_directed();
        test_random(400);
        write_model(32'd3);
        test_random(150);
        write_model(hsx_pkg::MODEL_HSV);
        test_random(300);
        write_model(hsx_pkg::MODEL_HSL);
        test_random(150);
        write_model(hsx_pkg::MODEL_HSI);
        test_random(260);
        drain_pipe();
        $display("Converted %0d pixels, %0d checked, across HSL, HSV, HSI and code 3.",
                 pixels_sent, pixels_checked);
        if (errors == 0 && rgb_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
